### sv/frame_stack_accumulator_top_defines.svh
// assertion macros for the frame stacking block
`ifndef FRAME_STACK_ACCUMULATOR_TOP_DEFINES_SVH
`define FRAME_STACK_ACCUMULATOR_TOP_DEFINES_SVH

`ifndef ASSERT_OFF

`define ASSERT_HOLDS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define ASSERT_HOLDS(lbl, prop, msg)

`define ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

### sv/fsa_pkg.sv
package fsa_pkg;

	localparam int INDEX_W = 16;
	localparam int DEPTH   = 2 ** INDEX_W;
	localparam int SUM_W   = 32;
	localparam int PIX_W   = 8;
	localparam int FC_W    = 16;
	localparam int NUM_W   = 48;
	localparam int DEN_W   = 40;
	localparam int QUO_W   = 8;
	localparam int CNT_W   = $clog2(QUO_W + 1);

	localparam logic [14:0] NORM_MUL = 15'd25599;

	typedef enum logic [1:0] {
		KIND_ACC  = 2'd0,
		KIND_SCAN = 2'd1,
		KIND_EMIT = 2'd2,
		KIND_NONE = 2'd3
	} kind_t;

	localparam logic [2:0] MODE_NORM  = 3'd0;
	localparam logic [2:0] MODE_RANGE = 3'd1;
	localparam logic [2:0] MODE_MIN   = 3'd2;
	localparam logic [2:0] MODE_MAX   = 3'd3;
	localparam logic [2:0] MODE_COUNT = 3'd4;
	localparam logic [2:0] MODE_MEAN  = 3'd5;

	localparam logic [1:0] REG_MODE   = 2'd0;
	localparam logic [1:0] REG_INVERT = 2'd1;
	localparam logic [1:0] REG_THRESH = 2'd2;
	localparam logic [1:0] REG_FILL   = 2'd3;

	typedef struct packed {
		logic [2:0]       mode;
		logic             invert;
		logic [PIX_W-1:0] thresh;
		logic [PIX_W-1:0] fill;
	} cfg_t;

	typedef struct packed {
		logic accept;
		logic exec;
		logic div_step;
		logic load_out;
	} dp_cmd_t;

	typedef struct packed {
		kind_t kind;
		logic  div_last;
		logic  out_full;
	} dp_stat_t;

	typedef struct packed {
		logic [SUM_W-1:0] sum;
		logic [PIX_W-1:0] mn;
		logic [PIX_W-1:0] mx;
		logic [PIX_W-1:0] nz;
	} entry_t;

endpackage

### sv/fsa_ctrl.sv
module fsa_ctrl import fsa_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  logic     out_ready,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_EXEC,
		ST_DIV,
		ST_FIN
	} state_t;

	state_t state_q;
	logic   ready_q;

	always_comb begin
		cmd.accept   = in_valid && ready_q;
		cmd.exec     = (state_q == ST_EXEC);
		cmd.div_step = (state_q == ST_DIV);
		cmd.load_out = (state_q == ST_FIN) && (!stat.out_full || out_ready);
	end

	assign in_ready = ready_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ready_q <= 1'b1;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.accept) begin
						state_q <= ST_READ;
						ready_q <= 1'b0;
					end
				end
				ST_READ: begin
					state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					if (stat.kind == KIND_EMIT) begin
						state_q <= ST_DIV;
					end else begin
						state_q <= ST_IDLE;
						ready_q <= 1'b1;
					end
				end
				ST_DIV: begin
					if (stat.div_last) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					// wait here while the previous result is still held
					if (cmd.load_out) begin
						state_q <= ST_IDLE;
						ready_q <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
					ready_q <= 1'b1;
				end
			endcase
		end
	end

endmodule

### sv/fsa_dp.sv
module fsa_dp import fsa_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_t               cfg,
	input  dp_cmd_t            cmd,
	output dp_stat_t           stat,
	input  logic [1:0]         in_kind,
	input  logic [INDEX_W-1:0] in_index,
	input  logic [PIX_W-1:0]   in_value,
	input  logic               in_restart,
	input  logic               in_eof,
	output logic [PIX_W-1:0]   out_pixel,
	output logic [SUM_W-1:0]   out_sum,
	output logic               out_valid,
	input  logic               out_ready
);

	entry_t mem [DEPTH];
	entry_t rd_q;
	entry_t wr_data;
	logic   wr_en;

	kind_t              kind_q;
	logic [INDEX_W-1:0] idx_q;
	logic [PIX_W-1:0]   val_q;
	logic               rst_q;
	logic               eof_q;

	logic [FC_W-1:0]  fc_q;
	logic [SUM_W-1:0] low_q;
	logic [SUM_W-1:0] high_q;

	logic [NUM_W-1:0] rem_q;
	logic [NUM_W-1:0] dsh_q;
	logic [QUO_W-1:0] quo_q;
	logic             sat_q;
	logic [CNT_W-1:0] cnt_q;
	logic             direct_q;
	logic [PIX_W-1:0] dpx_q;
	logic [SUM_W-1:0] sum_q;

	logic [PIX_W-1:0] pix_q;
	logic [SUM_W-1:0] osum_q;
	logic             full_q;

	logic [SUM_W:0]   sum_ext;
	logic [SUM_W-1:0] sum_sat;
	logic [PIX_W-1:0] nz_inc;
	logic [SUM_W-1:0] lo_base;
	logic [SUM_W-1:0] hi_base;
	logic [SUM_W-1:0] diff_s;
	logic [SUM_W-1:0] span;
	logic [NUM_W-1:0] num_n;
	logic [DEN_W-1:0] den_n;
	logic             direct_n;
	logic [PIX_W-1:0] dpx_n;
	logic             ge;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			rd_q <= mem[in_index];
		end
		if (wr_en) begin
			mem[idx_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q <= KIND_NONE;
		end else if (cmd.accept) begin
			kind_q <= kind_t'(in_kind);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			idx_q <= in_index;
			val_q <= cfg.invert ? ~in_value : in_value;
			rst_q <= in_restart;
			eof_q <= in_eof;
		end
	end

	// accumulate update
	always_comb begin
		sum_ext = {1'b0, rd_q.sum} + (SUM_W + 1)'(val_q);
		sum_sat = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
		nz_inc  = (val_q != '0 && rd_q.nz != '1) ? rd_q.nz + 1'b1 : rd_q.nz;
		if (rst_q) begin
			wr_data.sum = SUM_W'(val_q);
			wr_data.mn  = val_q;
			wr_data.mx  = val_q;
			wr_data.nz  = PIX_W'(val_q != '0);
		end else begin
			wr_data.sum = sum_sat;
			wr_data.mn  = (val_q < rd_q.mn) ? val_q : rd_q.mn;
			wr_data.mx  = (val_q > rd_q.mx) ? val_q : rd_q.mx;
			wr_data.nz  = nz_inc;
		end
		wr_en = cmd.exec && (kind_q == KIND_ACC);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fc_q   <= '0;
			low_q  <= '1;
			high_q <= '0;
		end else if (cmd.exec) begin
			if (kind_q == KIND_ACC && eof_q) begin
				if (rst_q) begin
					fc_q <= FC_W'(1);
				end else if (fc_q != '1) begin
					fc_q <= fc_q + 1'b1;
				end
			end
			if (kind_q == KIND_SCAN) begin
				low_q  <= (rd_q.sum < lo_base) ? rd_q.sum : lo_base;
				high_q <= (rd_q.sum > hi_base) ? rd_q.sum : hi_base;
			end
		end
	end

	// emit operand selection
	always_comb begin
		lo_base  = rst_q ? '1 : low_q;
		hi_base  = rst_q ? '0 : high_q;
		diff_s   = rd_q.sum - low_q;
		span     = high_q - low_q;
		num_n    = NUM_W'(rd_q.sum);
		den_n    = DEN_W'(fc_q);
		direct_n = 1'b1;
		dpx_n    = '0;
		unique case (cfg.mode)
			MODE_NORM: begin
				num_n = NUM_W'(diff_s) * NUM_W'(NORM_MUL);
				// span times 100 as shifts
				den_n = (DEN_W'(span) << 6) + (DEN_W'(span) << 5) + (DEN_W'(span) << 2);
				if (high_q <= low_q || rd_q.sum <= low_q) begin
					dpx_n = '0;
				end else if (rd_q.sum >= high_q) begin
					dpx_n = '1;
				end else begin
					direct_n = 1'b0;
				end
			end
			MODE_RANGE: dpx_n = rd_q.mx - rd_q.mn;
			MODE_MIN:   dpx_n = rd_q.mn;
			MODE_MAX:   dpx_n = rd_q.mx;
			MODE_COUNT: begin
				den_n = DEN_W'(rd_q.nz);
				if (rd_q.nz == '0 || rd_q.nz < cfg.thresh) begin
					dpx_n = cfg.fill;
				end else begin
					direct_n = 1'b0;
				end
			end
			default: begin
				if (fc_q != '0) begin
					direct_n = 1'b0;
				end
			end
		endcase
	end

	assign ge = (rem_q >= dsh_q);

	// restoring divide, first step only tests for a quotient past 8 bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.exec && kind_q == KIND_EMIT) begin
			cnt_q <= CNT_W'(QUO_W);
		end else if (cmd.div_step) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec && kind_q == KIND_EMIT) begin
			rem_q    <= num_n;
			dsh_q    <= NUM_W'(den_n) << QUO_W;
			quo_q    <= '0;
			sat_q    <= 1'b0;
			direct_q <= direct_n;
			dpx_q    <= dpx_n;
			sum_q    <= rd_q.sum;
		end else if (cmd.div_step) begin
			if (cnt_q == CNT_W'(QUO_W)) begin
				sat_q <= ge;
			end else begin
				if (ge) begin
					rem_q <= rem_q - dsh_q;
				end
				quo_q <= {quo_q[QUO_W-2:0], ge};
			end
			dsh_q <= dsh_q >> 1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= 1'b0;
		end else if (cmd.load_out) begin
			full_q <= 1'b1;
		end else if (out_ready) begin
			full_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			pix_q  <= direct_q ? dpx_q : (sat_q ? '1 : quo_q);
			osum_q <= sum_q;
		end
	end

	assign out_pixel     = pix_q;
	assign out_sum       = osum_q;
	assign out_valid     = full_q;
	assign stat.kind     = kind_q;
	assign stat.div_last = (cnt_q == '0);
	assign stat.out_full = full_q;

endmodule

### sv/frame_stack_accumulator_top.sv
// channel   dir  handshake              payload
// s_axis    in   s_tvalid / s_tready    tdata index,value,restart; tuser kind; tlast eof
// m_axis    out  m_tvalid / m_tready    tdata pixel,sum
// cfg       in   cfg_wr_en              cfg_index, cfg_data
//
// accumulate, scan, ignored requests: address, memory read, write back (accumulate only)
// emit: address, memory read, setup, bit-serial divide of the result quotient, finish
// one request in flight at a time, the single-port pixel memory sets the sequence
// the result register frees the input side; an emit waits only if it is still full
// reset clears control, frame count and global range; pixel memory is not cleared
`include "frame_stack_accumulator_top_defines.svh"

module frame_stack_accumulator_top import fsa_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // index[15:0], value[23:16], restart[24]
	input  logic [1:0]  s_tuser,  // kind[1:0]
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,  // pixel[7:0], sum[39:8]
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);

	cfg_t     cfg_q;
	dp_cmd_t  cmd;
	dp_stat_t stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode   <= MODE_MEAN;
			cfg_q.invert <= 1'b0;
			cfg_q.thresh <= 8'd4;
			cfg_q.fill   <= 8'd150;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_MODE:   cfg_q.mode   <= cfg_data[2:0];
				REG_INVERT: cfg_q.invert <= cfg_data[0];
				REG_THRESH: cfg_q.thresh <= cfg_data;
				REG_FILL:   cfg_q.fill   <= cfg_data;
				default:    cfg_q        <= cfg_q;
			endcase
		end
	end

	fsa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_ready (m_tready),
		.stat      (stat),
		.cmd       (cmd)
	);

	fsa_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.cmd        (cmd),
		.stat       (stat),
		.in_kind    (s_tuser),
		.in_index   (s_tdata[15:0]),
		.in_value   (s_tdata[23:16]),
		.in_restart (s_tdata[24]),
		.in_eof     (s_tlast),
		.out_pixel  (m_tdata[7:0]),
		.out_sum    (m_tdata[39:8]),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready)
	);

	`ASSERT_NEXT(a_busy_after_req, s_tvalid && s_tready, !s_tready, "request taken while busy")
	`ASSERT_HOLDS(a_cmd_onehot, $onehot0({cmd.accept, cmd.exec, cmd.div_step, cmd.load_out}), "overlapping datapath commands")
	`ASSERT_HOLDS(a_no_overwrite, cmd.load_out |-> !(m_tvalid && !m_tready), "result overwritten while stalled")

endmodule
